>>> design/swas_pkg.sv
// shared types and constants for the sliding-window retransmission sender
// no dependencies; imported by every other file in design/
package swas_pkg;

   localparam int WINDOW    = 4;
   localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SEQ_W     = 16;
   localparam int CNT_W     = 17;
   localparam int CSR_IDX_W = 1;

   localparam logic [CNT_W-1:0]     ELAPSED_MAX   = '1;
   localparam logic [SEQ_W-1:0]     TIMEOUT_RESET = 16'd2000;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL     = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT   = 1'b1;

   typedef enum logic [1:0] {
      OP_POLL = 2'd0,
      OP_ACK  = 2'd1,
      OP_TICK = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      KIND_STATUS = 2'd0,
      KIND_SEND   = 2'd1,
      KIND_RESEND = 2'd2
   } kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POLL_EXP,
      ST_POLL_WIN,
      ST_POLL_CLAMP,
      ST_POLL_COMMIT,
      ST_SEND,
      ST_RESEND,
      ST_ACK_DIFF,
      ST_ACK_RANGE,
      ST_SLIDE,
      ST_TICK,
      ST_STATUS
   } state_type;

   // operand selection for the shared adder-subtractor
   typedef enum logic [3:0] {
      UOP_NONE,
      UOP_EXPIRY,
      UOP_WIN,
      UOP_CLAMP,
      UOP_COMMIT,
      UOP_CUR,
      UOP_ACK_BASE,
      UOP_ACK_NEXT,
      UOP_BASE_INC,
      UOP_TICK
   } uop_type;

   typedef struct packed {
      logic     req_ready;
      uop_type  uop;
      logic     set_expiry;
      logic     set_win;
      logic     set_lim;
      logic     commit;
      logic     emit;
      kind_type kind;
      logic     start_resend;
      logic     ack_diff;
      logic     ack_mark;
      logic     slide;
      logic     tick;
   } ctl_type;

   typedef struct packed {
      logic       req_valid;
      logic [1:0] op;
      logic       out_free;
      logic       cur_more;
      logic       expired;
      logic       any_out;
      logic       slide_ok;
   } sts_type;

endpackage

>>> design/swas_unit.sv
// shared 17-bit adder-subtractor with borrow flag
// depends on swas_pkg
module swas_unit import swas_pkg::*; (
   input  logic [CNT_W-1:0] opa,
   input  logic [CNT_W-1:0] opb,
   input  logic             sub,
   output logic [CNT_W-1:0] res,
   output logic             borrow
);

   logic [CNT_W:0] full;

   always_comb begin
      full = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + {{CNT_W{1'b0}}, sub};
   end

   assign res    = full[CNT_W-1:0];
   assign borrow = sub & ~full[CNT_W];

endmodule

>>> design/swas_ctrl.sv
// sequencer for poll, acknowledgement and tick handling
// depends on swas_pkg; drives the datapath in the top level through ctl_type
module swas_ctrl import swas_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  sts_type sts,
   output ctl_type ctl
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (sts.req_valid) begin
               case (sts.op)
                  OP_POLL: state_in = ST_POLL_EXP;
                  OP_ACK:  state_in = ST_ACK_DIFF;
                  OP_TICK: state_in = ST_TICK;
                  default: state_in = ST_STATUS;
               endcase
            end
         end
         ST_POLL_EXP:    state_in = ST_POLL_WIN;
         ST_POLL_WIN:    state_in = ST_POLL_CLAMP;
         ST_POLL_CLAMP:  state_in = ST_POLL_COMMIT;
         ST_POLL_COMMIT: state_in = ST_SEND;
         ST_SEND: begin
            if (!sts.cur_more) begin
               if (sts.expired) begin
                  state_in = ST_RESEND;
               end else if (sts.any_out) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_STATUS;
               end
            end
         end
         ST_RESEND: begin
            if (!sts.cur_more) begin
               state_in = sts.any_out ? ST_IDLE : ST_STATUS;
            end
         end
         ST_ACK_DIFF:  state_in = ST_ACK_RANGE;
         ST_ACK_RANGE: state_in = ST_SLIDE;
         ST_SLIDE: begin
            if (!sts.slide_ok) begin
               state_in = ST_STATUS;
            end
         end
         ST_TICK: state_in = ST_STATUS;
         ST_STATUS: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      ctl      = '0;
      ctl.uop  = UOP_NONE;
      ctl.kind = KIND_STATUS;
      case (state_ff)
         ST_IDLE: ctl.req_ready = 1'b1;
         ST_POLL_EXP: begin
            ctl.uop        = UOP_EXPIRY;
            ctl.set_expiry = 1'b1;
         end
         ST_POLL_WIN: begin
            ctl.uop     = UOP_WIN;
            ctl.set_win = 1'b1;
         end
         ST_POLL_CLAMP: begin
            ctl.uop     = UOP_CLAMP;
            ctl.set_lim = 1'b1;
         end
         ST_POLL_COMMIT: begin
            ctl.uop    = UOP_COMMIT;
            ctl.commit = 1'b1;
         end
         ST_SEND: begin
            ctl.uop          = UOP_CUR;
            ctl.kind         = KIND_SEND;
            ctl.emit         = sts.cur_more & sts.out_free;
            ctl.start_resend = ~sts.cur_more & sts.expired;
         end
         ST_RESEND: begin
            ctl.uop  = UOP_CUR;
            ctl.kind = KIND_RESEND;
            ctl.emit = sts.cur_more & sts.out_free;
         end
         ST_ACK_DIFF: begin
            ctl.uop      = UOP_ACK_BASE;
            ctl.ack_diff = 1'b1;
         end
         ST_ACK_RANGE: begin
            ctl.uop      = UOP_ACK_NEXT;
            ctl.ack_mark = 1'b1;
         end
         ST_SLIDE: begin
            ctl.uop   = UOP_BASE_INC;
            ctl.slide = sts.slide_ok;
         end
         ST_TICK: begin
            ctl.uop  = UOP_TICK;
            ctl.tick = 1'b1;
         end
         ST_STATUS: ctl.emit = sts.out_free;
         default: ctl.req_ready = 1'b0;
      endcase
   end

endmodule

>>> design/sliding_window_arq_sender_core.sv
// sliding-window retransmission sender: window state, timer, slot marks and result register
// depends on swas_pkg, swas_unit and swas_ctrl
//
//   channel | ports                              | direction | transfer when
//   req     | req_operation, req_ack_number      | in        | req_valid & req_ready
//   rsp     | rsp_kind .. rsp_last               | out       | rsp_valid & rsp_ready
//   csr     | csr_index, csr_wdata               | in        | csr_write
//
// poll: expiry, window-end, clamp and commit steps, then a result per new send and, once
// the timer has expired, per retransmission, or a status result if it sends nothing; ack:
// difference, range, a slide step per slot passed; ack, tick and other codes emit status
// all steps go through one shared 17-bit adder-subtractor under the sequencer
// reset is synchronous and sets window, marks, timer, config and rsp_valid to defaults
// a stalled rsp holds the sequencer only where it has a further result to emit

module sliding_window_arq_sender_core import swas_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_operation,
   input  logic [SEQ_W-1:0]     req_ack_number,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_kind,
   output logic [SEQ_W-1:0]     rsp_seq_number,
   output logic [SEQ_W-1:0]     rsp_window_base,
   output logic [SEQ_W-1:0]     rsp_next_seq,
   output logic                 rsp_timer_active,
   output logic                 rsp_transfer_done,
   output logic                 rsp_last,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SEQ_W-1:0]     csr_wdata
);

   localparam logic [SLOT_W:0]    WIN_S   = (SLOT_W+1)'(WINDOW);
   localparam logic [CNT_W-1:0]   WIN_C   = CNT_W'(WINDOW);
   localparam logic [SEQ_W-1:0]   WIN_Q   = SEQ_W'(WINDOW);
   localparam logic [CNT_W-1:0]   ONE_C   = CNT_W'(1);

   ctl_type ctl;
   sts_type sts;

   logic [SEQ_W-1:0]  total_ff, total_in;
   logic [SEQ_W-1:0]  timeout_ff, timeout_in;
   logic [SEQ_W-1:0]  base_ff, base_in;
   logic [SEQ_W-1:0]  next_ff, next_in;
   logic [SLOT_W-1:0] base_slot_ff, base_slot_in;
   logic [WINDOW-1:0] mark_ff, mark_in;
   logic              timer_ff, timer_in;
   logic [CNT_W-1:0]  elapsed_ff, elapsed_in;
   logic              expired_ff, expired_in;
   logic              any_out_ff, any_out_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [SEQ_W-1:0]  ack_ff, ack_in;
   logic [CNT_W-1:0]  win_end_ff, win_end_in;
   logic [CNT_W-1:0]  lim_ff, lim_in;
   logic [SEQ_W-1:0]  cur_ff, cur_in;
   logic              ack_ok_ff, ack_ok_in;
   logic [SLOT_W-1:0] ack_slot_ff, ack_slot_in;

   kind_type          kind_ff, kind_in;
   logic [SEQ_W-1:0]  seq_ff, seq_in;
   logic [SEQ_W-1:0]  wbase_ff, wbase_in;
   logic [SEQ_W-1:0]  wnext_ff, wnext_in;
   logic              wtimer_ff, wtimer_in;
   logic              wdone_ff, wdone_in;
   logic              wlast_ff, wlast_in;

   logic [CNT_W-1:0]  u_opa, u_opb, u_res;
   logic              u_sub, u_borrow;

   logic              req_fire, out_free, cur_last, item_last;
   logic [SLOT_W:0]   slot_sum, slot_inc;

   assign req_ready = ctl.req_ready;
   assign req_fire  = req_valid & ctl.req_ready;
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   swas_unit u_unit (
      .opa    (u_opa),
      .opb    (u_opb),
      .sub    (u_sub),
      .res    (u_res),
      .borrow (u_borrow)
   );

   swas_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .ctl   (ctl)
   );

   always_comb begin
      sts.req_valid = req_valid;
      sts.op        = req_operation;
      sts.out_free  = out_free;
      sts.cur_more  = (cur_ff != next_ff);
      sts.expired   = expired_ff;
      sts.any_out   = any_out_ff;
      sts.slide_ok  = (base_ff != next_ff) & mark_ff[base_slot_ff];
   end

   // operand selection for the shared unit
   always_comb begin
      u_opa = '0;
      u_opb = '0;
      u_sub = 1'b0;
      case (ctl.uop)
         UOP_EXPIRY: begin
            u_opa = {1'b0, timeout_ff};
            u_opb = elapsed_ff;
            u_sub = 1'b1;
         end
         UOP_WIN: begin
            u_opa = {1'b0, base_ff};
            u_opb = WIN_C;
         end
         UOP_CLAMP: begin
            u_opa = win_end_ff;
            u_opb = {1'b0, total_ff};
            u_sub = 1'b1;
         end
         UOP_COMMIT: begin
            u_opa = {1'b0, next_ff};
            u_opb = lim_ff;
            u_sub = 1'b1;
         end
         UOP_CUR: begin
            u_opa = {1'b0, cur_ff};
            u_opb = ONE_C;
         end
         UOP_ACK_BASE: begin
            u_opa = {1'b0, ack_ff};
            u_opb = {1'b0, base_ff};
            u_sub = 1'b1;
         end
         UOP_ACK_NEXT: begin
            u_opa = {1'b0, ack_ff};
            u_opb = {1'b0, next_ff};
            u_sub = 1'b1;
         end
         UOP_BASE_INC: begin
            u_opa = {1'b0, base_ff};
            u_opb = ONE_C;
         end
         UOP_TICK: begin
            u_opa = elapsed_ff;
            u_opb = ONE_C;
         end
         default: u_sub = 1'b0;
      endcase
   end

   always_comb begin
      slot_sum = {1'b0, base_slot_ff} + {1'b0, u_res[SLOT_W-1:0]};
      slot_inc = {1'b0, base_slot_ff} + (SLOT_W+1)'(1);
      cur_last = (u_res[SEQ_W-1:0] == next_ff);
      case (ctl.kind)
         KIND_SEND:   item_last = cur_last & ~expired_ff;
         KIND_RESEND: item_last = cur_last;
         default:     item_last = 1'b1;
      endcase
   end

   // next values of the window, timer and sequencing registers
   always_comb begin
      total_in     = total_ff;
      timeout_in   = timeout_ff;
      base_in      = base_ff;
      next_in      = next_ff;
      base_slot_in = base_slot_ff;
      mark_in      = mark_ff;
      timer_in     = timer_ff;
      elapsed_in   = elapsed_ff;
      expired_in   = expired_ff;
      any_out_in   = any_out_ff;
      ack_in       = ack_ff;
      win_end_in   = win_end_ff;
      lim_in       = lim_ff;
      cur_in       = cur_ff;
      ack_ok_in    = ack_ok_ff;
      ack_slot_in  = ack_slot_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_TOTAL:   total_in   = csr_wdata;
            CSR_TIMEOUT: timeout_in = csr_wdata;
            default:     total_in   = total_ff;
         endcase
      end

      if (req_fire) begin
         ack_in     = req_ack_number;
         any_out_in = 1'b0;
      end
      if (ctl.set_expiry) begin
         expired_in = timer_ff & u_borrow;
      end
      if (ctl.set_win) begin
         win_end_in = u_res;
      end
      if (ctl.set_lim) begin
         lim_in = u_borrow ? win_end_ff : {1'b0, total_ff};
      end
      if (ctl.commit) begin
         cur_in = next_ff;
         if (u_borrow) begin
            next_in = lim_ff[SEQ_W-1:0];
            if (base_ff == next_ff) begin
               timer_in   = 1'b1;
               elapsed_in = '0;
            end
         end
      end
      if (ctl.emit) begin
         any_out_in = 1'b1;
         if (ctl.kind != KIND_STATUS) begin
            cur_in = u_res[SEQ_W-1:0];
         end
      end
      if (ctl.start_resend) begin
         cur_in     = base_ff;
         timer_in   = 1'b1;
         elapsed_in = '0;
      end
      if (ctl.ack_diff) begin
         ack_ok_in   = ~u_borrow & (u_res[SEQ_W-1:0] < WIN_Q);
         ack_slot_in = (slot_sum >= WIN_S) ? SLOT_W'(slot_sum - WIN_S)
                                           : slot_sum[SLOT_W-1:0];
      end
      if (ctl.ack_mark && ack_ok_ff && u_borrow) begin
         mark_in[ack_slot_ff] = 1'b1;
      end
      if (ctl.slide) begin
         mark_in[base_slot_ff] = 1'b0;
         base_in               = u_res[SEQ_W-1:0];
         base_slot_in          = (slot_inc == WIN_S) ? '0 : slot_inc[SLOT_W-1:0];
         if (u_res[SEQ_W-1:0] == next_ff) begin
            timer_in = 1'b0;
         end else begin
            timer_in   = 1'b1;
            elapsed_in = '0;
         end
      end
      if (ctl.tick && timer_ff && (elapsed_ff != ELAPSED_MAX)) begin
         elapsed_in = u_res;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      seq_in       = seq_ff;
      wbase_in     = wbase_ff;
      wnext_in     = wnext_ff;
      wtimer_in    = wtimer_ff;
      wdone_in     = wdone_ff;
      wlast_in     = wlast_ff;
      if (ctl.emit) begin
         rsp_valid_in = 1'b1;
         kind_in      = ctl.kind;
         seq_in       = (ctl.kind == KIND_STATUS) ? '0 : cur_ff;
         wbase_in     = base_ff;
         wnext_in     = next_ff;
         wtimer_in    = timer_ff;
         wdone_in     = (base_ff >= total_ff);
         wlast_in     = item_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff     <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         base_ff      <= '0;
         next_ff      <= '0;
         base_slot_ff <= '0;
         mark_ff      <= '0;
         timer_ff     <= 1'b0;
         elapsed_ff   <= '0;
         expired_ff   <= 1'b0;
         any_out_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         total_ff     <= total_in;
         timeout_ff   <= timeout_in;
         base_ff      <= base_in;
         next_ff      <= next_in;
         base_slot_ff <= base_slot_in;
         mark_ff      <= mark_in;
         timer_ff     <= timer_in;
         elapsed_ff   <= elapsed_in;
         expired_ff   <= expired_in;
         any_out_ff   <= any_out_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ack_ff      <= ack_in;
      win_end_ff  <= win_end_in;
      lim_ff      <= lim_in;
      cur_ff      <= cur_in;
      ack_ok_ff   <= ack_ok_in;
      ack_slot_ff <= ack_slot_in;
      kind_ff     <= kind_in;
      seq_ff      <= seq_in;
      wbase_ff    <= wbase_in;
      wnext_ff    <= wnext_in;
      wtimer_ff   <= wtimer_in;
      wdone_ff    <= wdone_in;
      wlast_ff    <= wlast_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_seq_number    = seq_ff;
   assign rsp_window_base   = wbase_ff;
   assign rsp_next_seq      = wnext_ff;
   assign rsp_timer_active  = wtimer_ff;
   assign rsp_transfer_done = wdone_ff;
   assign rsp_last          = wlast_ff;

   a_base_le_next: assert property (@(posedge clock) disable iff (reset)
      base_ff <= next_ff)
      else $error("window base passed next sequence number");

   a_window_span: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, next_ff} - {1'b0, base_ff}) <= WIN_C)
      else $error("outstanding span exceeds window");

   a_timer_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.req_ready |-> (timer_ff == (base_ff != next_ff)))
      else $error("timer state disagrees with outstanding window");

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      ctl.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over an untaken transfer");

endmodule

>>> dv/tb_sliding_window_arq_sender_core.sv
`timescale 1ns / 100ps
// testbench for sliding_window_arq_sender_core: directed and random request streams with
// random idling, checked against a window/timer predictor kept in this file
// depends on swas_pkg and the design files
module tb_sliding_window_arq_sender_core;
   import swas_pkg::*;

   localparam logic [1:0]  OP_UNUSED     = 2'd3;
   localparam int unsigned LIMIT_CYCLES  = 400000;
   localparam int unsigned SETTLE_CYCLES = 24;
   localparam int unsigned DRAIN_LIMIT   = 6000;
   localparam int unsigned HOLD_CYCLES   = 250;
   localparam int unsigned PRINT_CAP     = 60;

   typedef struct packed {
      logic [1:0]       op;
      logic [SEQ_W-1:0] ack;
   } req_item_type;

   typedef struct {
      kind_type         kind;
      logic [SEQ_W-1:0] seq;
      logic [SEQ_W-1:0] base;
      logic [SEQ_W-1:0] next;
      logic             timer;
      logic             done;
      logic             is_last;
   } sender_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_operation = OP_POLL;
   logic [SEQ_W-1:0]     req_ack_number = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_kind;
   logic [SEQ_W-1:0]     rsp_seq_number;
   logic [SEQ_W-1:0]     rsp_window_base;
   logic [SEQ_W-1:0]     rsp_next_seq;
   logic                 rsp_timer_active;
   logic                 rsp_transfer_done;
   logic                 rsp_last;
   logic                 csr_write = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = CSR_TOTAL;
   logic [SEQ_W-1:0]     csr_wdata = '0;

   // window and timer as the block should hold them
   int unsigned cfg_total   = 0;
   int unsigned cfg_timeout = TIMEOUT_RESET;
   int unsigned win_base    = 0;
   int unsigned win_next    = 0;
   bit          slot_mark[WINDOW];
   bit          rtx_running = 1'b0;
   int unsigned rtx_elapsed = 0;

   req_item_type      queued_requests[$];
   sender_result_type awaited_results[$];
   req_item_type      next_req;

   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned hold_asked     = 0;
   int unsigned hold_seen      = 0;
   int unsigned hold_left      = 0;
   int unsigned drv_gap        = 0;
   int unsigned drv_calm       = 0;
   int unsigned rcv_stall      = 0;
   int unsigned rcv_calm       = 0;

   sliding_window_arq_sender_core u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_ack_number    (req_ack_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_kind          (rsp_kind),
      .rsp_seq_number    (rsp_seq_number),
      .rsp_window_base   (rsp_window_base),
      .rsp_next_seq      (rsp_next_seq),
      .rsp_timer_active  (rsp_timer_active),
      .rsp_transfer_done (rsp_transfer_done),
      .rsp_last          (rsp_last),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #6 clock = ~clock;

   task automatic flag_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= PRINT_CAP)
         $display("[%0t] mismatch: %s", $time, msg);
   endtask

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // one accepted request: update window and timer, queue the results it causes
   function automatic void step_sender_window(logic [1:0] op, logic [SEQ_W-1:0] ack_in);
      kind_type          kinds[$];
      int unsigned       seqs[$];
      int unsigned       ack;
      int unsigned       s;
      sender_result_type r;
      ack = 32'(ack_in);
      if (op == OP_POLL) begin
         while (win_next < win_base + WINDOW && win_next < cfg_total) begin
            kinds.push_back(KIND_SEND);
            seqs.push_back(win_next);
            if (win_base == win_next) begin
               rtx_running = 1'b1;
               rtx_elapsed = 0;
            end
            win_next++;
         end
         if (rtx_running && rtx_elapsed > cfg_timeout) begin
            for (s = win_base; s < win_next; s++) begin
               kinds.push_back(KIND_RESEND);
               seqs.push_back(s);
            end
            rtx_running = 1'b1;
            rtx_elapsed = 0;
         end
      end else if (op == OP_ACK) begin
         if (ack >= win_base && ack < win_next && ack < win_base + WINDOW) begin
            slot_mark[ack % WINDOW] = 1'b1;
            while (win_base < win_next && slot_mark[win_base % WINDOW]) begin
               slot_mark[win_base % WINDOW] = 1'b0;
               win_base++;
               if (win_base == win_next) begin
                  rtx_running = 1'b0;
               end else begin
                  rtx_running = 1'b1;
                  rtx_elapsed = 0;
               end
            end
         end
      end else if (op == OP_TICK) begin
         if (rtx_running && rtx_elapsed < ELAPSED_MAX)
            rtx_elapsed++;
      end
      if (kinds.size() == 0) begin
         kinds.push_back(KIND_STATUS);
         seqs.push_back(0);
      end
      foreach (kinds[k]) begin
         r.kind    = kinds[k];
         r.seq     = seqs[k][SEQ_W-1:0];
         r.base    = win_base[SEQ_W-1:0];
         r.next    = win_next[SEQ_W-1:0];
         r.timer   = rtx_running;
         r.done    = (win_base >= cfg_total);
         r.is_last = (k == kinds.size() - 1);
         awaited_results.push_back(r);
      end
   endfunction

   task automatic check_result();
      sender_result_type want;
      if (awaited_results.size() == 0) begin
         flag_mismatch($sformatf("result with nothing outstanding, kind %0d seq %0d",
                                 rsp_kind, rsp_seq_number));
         return;
      end
      want = awaited_results.pop_front();
      if (rsp_kind !== want.kind)
         flag_mismatch($sformatf("kind %0d, want %0d", rsp_kind, want.kind));
      if (rsp_seq_number !== want.seq)
         flag_mismatch($sformatf("seq_number %0d, want %0d", rsp_seq_number, want.seq));
      if (rsp_window_base !== want.base)
         flag_mismatch($sformatf("window_base %0d, want %0d", rsp_window_base, want.base));
      if (rsp_next_seq !== want.next)
         flag_mismatch($sformatf("next_seq %0d, want %0d", rsp_next_seq, want.next));
      if (rsp_timer_active !== want.timer)
         flag_mismatch($sformatf("timer_active %b, want %b", rsp_timer_active, want.timer));
      if (rsp_transfer_done !== want.done)
         flag_mismatch($sformatf("transfer_done %b, want %b", rsp_transfer_done, want.done));
      if (rsp_last !== want.is_last)
         flag_mismatch($sformatf("last %b, want %b", rsp_last, want.is_last));
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         drv_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            step_sender_window(req_operation, req_ack_number);
            if (drv_calm > 0) begin
               drv_calm--;
               drv_gap = 0;
            end else if ($urandom_range(0, 39) == 0) begin
               drv_calm = 20;
               drv_gap = 0;
            end else begin
               drv_gap = pick_gap();
            end
         end
         if (!req_valid || req_ready) begin
            if (drv_gap > 0) begin
               drv_gap--;
               req_valid <= 1'b0;
            end else if (queued_requests.size() != 0) begin
               next_req = queued_requests.pop_front();
               req_valid      <= 1'b1;
               req_operation  <= next_req.op;
               req_ack_number <= next_req.ack;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor and receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready)
            check_result();
         if (hold_seen != hold_asked) begin
            hold_seen = hold_asked;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (rcv_stall > 0) begin
            rcv_stall--;
            rsp_ready <= 1'b0;
         end else if (rcv_calm > 0) begin
            rcv_calm--;
            rsp_ready <= 1'b1;
         end else if ($urandom_range(0, 59) == 0) begin
            rcv_calm = 30;
            rsp_ready <= 1'b1;
         end else begin
            if ($urandom_range(0, 3) == 0)
               rcv_stall = pick_gap();
            if (rcv_stall > 0) begin
               rcv_stall--;
               rsp_ready <= 1'b0;
            end else begin
               rsp_ready <= 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [SEQ_W-1:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      if (idx == CSR_TOTAL)
         cfg_total = 32'(value);
      else
         cfg_timeout = 32'(value);
   endtask

   task automatic push_req(logic [1:0] op, logic [SEQ_W-1:0] ack);
      req_item_type it;
      it.op  = op;
      it.ack = ack;
      queued_requests.push_back(it);
   endtask

   task automatic wait_idle();
      while (queued_requests.size() != 0 || req_valid || awaited_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // polls, acks, ticks and unused codes; acks mostly inside the outstanding window, some stale, unsent or random
   function automatic req_item_type pick_request();
      req_item_type it;
      int unsigned  r;
      int unsigned  span;
      r = $urandom_range(0, 99);
      it.ack = 16'($urandom);
      span = win_next - win_base;
      if (r < 38) begin
         it.op = OP_POLL;
      end else if (r < 72) begin
         it.op = OP_ACK;
         case ($urandom_range(0, 9))
            0: it.ack = 16'($urandom);
            1: it.ack = win_next[SEQ_W-1:0];
            2: it.ack = 16'(win_base - 1);
            default: begin
               if (span > 0)
                  it.ack = 16'(win_base + $urandom_range(0, span - 1));
            end
         endcase
      end else if (r < 95) begin
         it.op = OP_TICK;
      end else begin
         it.op = OP_UNUSED;
      end
      return it;
   endfunction

   task automatic run_random(int unsigned count, bit with_hold);
      int unsigned i;
      for (i = 0; i < count; i++) begin
         while (queued_requests.size() > 1)
            @(posedge clock);
         if (with_hold && i == 4)
            hold_asked++;
         queued_requests.push_back(pick_request());
      end
      wait_idle();
   endtask

   initial begin
      int unsigned drain;
      foreach (slot_mark[i])
         slot_mark[i] = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // nothing to send, timer stopped
      write_csr(CSR_TOTAL, 16'd0);
      write_csr(CSR_TIMEOUT, 16'd0);
      push_req(OP_POLL, 16'h0000);
      push_req(OP_UNUSED, 16'hFFFF);
      push_req(OP_TICK, 16'h5A5A);
      push_req(OP_ACK, 16'd0);
      push_req(OP_ACK, 16'hFFFF);
      wait_idle();

      // fill the window, expire, out-of-order and duplicate acks, slide to the end
      write_csr(CSR_TOTAL, 16'd6);
      push_req(OP_POLL, 16'hA5A5);
      push_req(OP_POLL, 16'h0000);
      push_req(OP_TICK, 16'h0000);
      push_req(OP_POLL, 16'h0000);
      push_req(OP_ACK, 16'd2);
      push_req(OP_ACK, 16'd2);
      push_req(OP_ACK, 16'd4);
      push_req(OP_ACK, 16'd1);
      push_req(OP_ACK, 16'd0);
      push_req(OP_TICK, 16'h0000);
      push_req(OP_POLL, 16'h0000);
      push_req(OP_ACK, 16'd2);
      push_req(OP_ACK, 16'd3);
      push_req(OP_ACK, 16'd5);
      push_req(OP_ACK, 16'd4);
      push_req(OP_POLL, 16'h0000);
      wait_idle();

      write_csr(CSR_TOTAL, 16'hFFFF);
      write_csr(CSR_TIMEOUT, 16'hFFFF);
      push_req(OP_POLL, 16'h0000);
      push_req(OP_TICK, 16'h0000);
      push_req(OP_POLL, 16'h0000);
      wait_idle();

      // total lowered below what has been issued
      write_csr(CSR_TOTAL, 16'd3);
      push_req(OP_POLL, 16'h0000);
      push_req(OP_ACK, 16'd6);
      wait_idle();

      write_csr(CSR_TOTAL, 16'd48);
      write_csr(CSR_TIMEOUT, 16'd2);
      run_random(22, 1'b0);

      write_csr(CSR_TOTAL, 16'hFFFF);
      write_csr(CSR_TIMEOUT, 16'd1);
      run_random(22, 1'b1);

      write_csr(CSR_TOTAL, 16'(win_next + 16));
      write_csr(CSR_TIMEOUT, 16'd0);
      run_random(18, 1'b0);

      write_csr(CSR_TOTAL, 16'((win_next > 2) ? win_next - 2 : 0));
      run_random(10, 1'b0);

      write_csr(CSR_TOTAL, 16'(win_next + 12));
      write_csr(CSR_TIMEOUT, 16'hFFFF);
      run_random(12, 1'b0);

      while (queued_requests.size() != 0 || req_valid)
         @(posedge clock);
      drain = 0;
      while (awaited_results.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (awaited_results.size() != 0)
         flag_mismatch($sformatf("%0d results never arrived", awaited_results.size()));

      if (mismatch_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

>>> sim.f
design/swas_pkg.sv
design/swas_unit.sv
design/swas_ctrl.sv
design/sliding_window_arq_sender_core.sv
dv/tb_sliding_window_arq_sender_core.sv
